// File: hdl/hallct_pkg.sv
// Shared constants and lookup functions for the hall commutation block.
`default_nettype none

package hallct_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned DutyW     = 10;
  localparam int unsigned HallW     = 3;
  localparam int unsigned ForceW    = 2;
  localparam int unsigned NumLegs   = 6;
  localparam int unsigned NumPhases = 3;
  localparam int unsigned PhaseW    = 2;

  localparam logic [CfgIdxW-1:0] CfgTripThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgThrottleLow   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgThrottleHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDutyFloor     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDutyCeiling   = 3'd4;

  localparam logic [SampleW-1:0] TripThresholdRst = 12'd2745;
  localparam logic [SampleW-1:0] ThrottleLowRst   = 12'd678;
  localparam logic [SampleW-1:0] ThrottleHighRst  = 12'd3500;
  localparam logic [DutyW-1:0]   DutyFloorRst     = 10'd8;
  localparam logic [DutyW-1:0]   DutyCeilingRst   = 10'd700;
  localparam logic [DutyW-1:0]   DutyValueRst     = 10'd8;

  localparam logic [ForceW-1:0] ForceNone = 2'd0;
  localparam logic [ForceW-1:0] ForceLow  = 2'd1;
  localparam logic [ForceW-1:0] ForceHigh = 2'd2;
  localparam logic [ForceW-1:0] ForcePwm  = 2'd3;

  localparam logic [PhaseW-1:0] PhaseA    = 2'd0;
  localparam logic [PhaseW-1:0] PhaseB    = 2'd1;
  localparam logic [PhaseW-1:0] PhaseC    = 2'd2;
  localparam logic [PhaseW-1:0] PhaseNone = 2'd3;

  // duty = (2197 * t + 694580) / 10000, division by exact reciprocal multiply
  localparam int unsigned     DutyProdW  = 48;
  localparam int unsigned     DutyShift  = 37;
  localparam longint unsigned DutyDiv    = 10000;
  localparam longint unsigned DutyRecip  = ((64'd1 << DutyShift) + DutyDiv - 1) / DutyDiv;
  localparam longint unsigned DutyGain   = 2197;
  localparam longint unsigned DutyOffset = 689580 + 5000;
  localparam logic [DutyProdW-1:0] DutyMul = DutyProdW'(DutyGain * DutyRecip);
  localparam logic [DutyProdW-1:0] DutyAdd = DutyProdW'(DutyOffset * DutyRecip);

  function automatic logic [PhaseW-1:0] pwm_phase_f(input logic [HallW-1:0] hall);
    logic [PhaseW-1:0] ph;
    case (hall)
      3'd1:    ph = PhaseA;
      3'd2:    ph = PhaseB;
      3'd3:    ph = PhaseB;
      3'd4:    ph = PhaseC;
      3'd5:    ph = PhaseA;
      3'd6:    ph = PhaseC;
      default: ph = PhaseNone;
    endcase
    return ph;
  endfunction

  function automatic logic [PhaseW-1:0] gnd_phase_f(input logic [HallW-1:0] hall);
    logic [PhaseW-1:0] ph;
    case (hall)
      3'd1:    ph = PhaseC;
      3'd2:    ph = PhaseA;
      3'd3:    ph = PhaseC;
      3'd4:    ph = PhaseB;
      3'd5:    ph = PhaseB;
      3'd6:    ph = PhaseA;
      default: ph = PhaseNone;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

// File: hdl/hall_commutation_with_trip_and_throttle.sv
// Six-step hall commutation with overcurrent trip latch and throttle-to-duty map.
// Path: input register, then result register, from input transfer to result transfer.
// Throughput: one item per cycle while the output is not stalled; the result register is the block state itself.
// An item that stalls at the output holds the input register and then the input side.
// Reset: gate forces 0, running 1, duty 8, config registers at their defaults.
`default_nettype none

module hall_commutation_with_trip_and_throttle
  import hallct_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic                func_i,
  input  wire logic [HallW-1:0]    hall_state_i,
  input  wire logic [SampleW-1:0]  current_sample_i,
  input  wire logic [SampleW-1:0]  throttle_sample_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [ForceW-1:0]   force_a_high_o,
  output      logic [ForceW-1:0]   force_a_low_o,
  output      logic [ForceW-1:0]   force_b_high_o,
  output      logic [ForceW-1:0]   force_b_low_o,
  output      logic [ForceW-1:0]   force_c_high_o,
  output      logic [ForceW-1:0]   force_c_low_o,
  output      logic [DutyW-1:0]    duty_compare_o,
  output      logic                running_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [SampleW-1:0] trip_q;
  logic [SampleW-1:0] thr_low_q;
  logic [SampleW-1:0] thr_high_q;
  logic [DutyW-1:0]   duty_floor_q;
  logic [DutyW-1:0]   duty_ceil_q;

  logic               s1_valid_q;
  logic               s1_func_q;
  logic [HallW-1:0]   s1_hall_q;
  logic [SampleW-1:0] s1_cur_q;
  logic [SampleW-1:0] s1_thr_q;

  logic               out_valid_q;
  logic [ForceW-1:0]  forces_q [NumLegs];
  logic [ForceW-1:0]  forces_d [NumLegs];
  logic [ForceW-1:0]  comm_forces [NumLegs];
  logic               enabled_q;
  logic               enabled_d;
  logic [DutyW-1:0]   duty_q;
  logic [DutyW-1:0]   duty_d;

  logic               out_load;
  logic               s1_fire;
  logic               in_xfer;
  logic [PhaseW-1:0]  pwm_ph;
  logic [PhaseW-1:0]  gnd_ph;
  logic               hall_ok;
  logic [DutyProdW-1:0] duty_prod;
  logic [DutyW-1:0]   duty_lin;
  logic [DutyW-1:0]   duty_map;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_q       <= TripThresholdRst;
      thr_low_q    <= ThrottleLowRst;
      thr_high_q   <= ThrottleHighRst;
      duty_floor_q <= DutyFloorRst;
      duty_ceil_q  <= DutyCeilingRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTripThreshold: trip_q       <= cfg_data_i;
        CfgThrottleLow:   thr_low_q    <= cfg_data_i;
        CfgThrottleHigh:  thr_high_q   <= cfg_data_i;
        CfgDutyFloor:     duty_floor_q <= cfg_data_i[DutyW-1:0];
        CfgDutyCeiling:   duty_ceil_q  <= cfg_data_i[DutyW-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q <= func_i;
      s1_hall_q <= hall_state_i;
      s1_cur_q  <= current_sample_i;
      s1_thr_q  <= throttle_sample_i;
    end
  end

  assign pwm_ph  = pwm_phase_f(s1_hall_q);
  assign gnd_ph  = gnd_phase_f(s1_hall_q);
  assign hall_ok = (pwm_ph != PhaseNone) && (gnd_ph != PhaseNone);

  always_comb begin
    for (int i = 0; i < NumLegs; i++) begin
      if (PhaseW'(i >> 1) == pwm_ph) begin
        comm_forces[i] = ForcePwm;
      end else if (i[0] && (PhaseW'(i >> 1) == gnd_ph)) begin
        comm_forces[i] = ForceLow;
      end else begin
        comm_forces[i] = ForceHigh;
      end
    end
  end

  assign duty_prod = DutyProdW'(s1_thr_q) * DutyMul + DutyAdd;
  assign duty_lin  = duty_prod[DutyShift +: DutyW];

  always_comb begin
    if (s1_thr_q <= thr_low_q) begin
      duty_map = duty_floor_q;
    end else if (s1_thr_q >= thr_high_q) begin
      duty_map = duty_ceil_q;
    end else begin
      duty_map = duty_lin;
    end
  end

  always_comb begin
    forces_d  = forces_q;
    enabled_d = enabled_q;
    duty_d    = duty_q;
    if (s1_fire) begin
      if (!s1_func_q) begin
        if (enabled_q && hall_ok) begin
          forces_d = comm_forces;
        end
      end else begin
        if (s1_cur_q >= trip_q) begin
          enabled_d = 1'b0;
          for (int i = 0; i < NumLegs; i++) begin
            forces_d[i] = ForceLow;
          end
        end
        duty_d = duty_map;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      enabled_q   <= 1'b1;
      duty_q      <= DutyValueRst;
      forces_q    <= '{default: ForceNone};
    end else begin
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      enabled_q <= enabled_d;
      duty_q    <= duty_d;
      forces_q  <= forces_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign force_a_high_o = forces_q[0];
  assign force_a_low_o  = forces_q[1];
  assign force_b_high_o = forces_q[2];
  assign force_b_low_o  = forces_q[3];
  assign force_c_high_o = forces_q[4];
  assign force_c_low_o  = forces_q[5];
  assign duty_compare_o = duty_q;
  assign running_o      = enabled_q;

`ifndef SYNTHESIS
  a_trip_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enabled_q |=> !enabled_q)
    else $error("trip latch cleared without reset");

  a_trip_forces_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_o |-> (force_a_high_o == ForceLow) && (force_a_low_o == ForceLow) &&
                   (force_b_high_o == ForceLow) && (force_b_low_o == ForceLow) &&
                   (force_c_high_o == ForceLow) && (force_c_low_o == ForceLow))
    else $error("gate forces not low while tripped");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with no item held");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("item advanced without a result");

  a_state_holds_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(duty_q) && $stable(enabled_q))
    else $error("block state moved under a stalled result");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the hall commutation block with overcurrent trip and throttle map.
module testbench;
  import hallct_pkg::*;

  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned LongHold    = 48;
  localparam int unsigned SettleDelay = 4;
  localparam int unsigned MaxPrinted  = 40;
  localparam int unsigned SampleMax   = 4095;
  localparam int unsigned DutyMax     = 1023;
  localparam int unsigned DutySlope   = 2197;
  localparam int unsigned DutyBias    = 694580;
  localparam int unsigned DutyScale   = 10000;
  localparam logic FuncHall = 1'b0;
  localparam logic FuncAdc  = 1'b1;
  localparam logic [HallW-1:0] HallAllLow  = 3'd0;
  localparam logic [HallW-1:0] HallAllHigh = 3'd7;

  typedef struct packed {
    logic [ForceW-1:0] a_high;
    logic [ForceW-1:0] a_low;
    logic [ForceW-1:0] b_high;
    logic [ForceW-1:0] b_low;
    logic [ForceW-1:0] c_high;
    logic [ForceW-1:0] c_low;
    logic [DutyW-1:0]  duty;
    logic              run;
  } drive_state_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic [HallW-1:0]    hall_state;
  logic [SampleW-1:0]  current_sample;
  logic [SampleW-1:0]  throttle_sample;
  logic                out_valid;
  logic                out_stall;
  logic [ForceW-1:0]   force_a_high;
  logic [ForceW-1:0]   force_a_low;
  logic [ForceW-1:0]   force_b_high;
  logic [ForceW-1:0]   force_b_low;
  logic [ForceW-1:0]   force_c_high;
  logic [ForceW-1:0]   force_c_low;
  logic [DutyW-1:0]    duty_compare;
  logic                running;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  logic [ForceW-1:0]  gate_force [NumLegs];
  logic               drive_on;
  logic [DutyW-1:0]   duty_now;
  logic [SampleW-1:0] trip_level;
  logic [SampleW-1:0] thr_low;
  logic [SampleW-1:0] thr_high;
  logic [DutyW-1:0]   duty_min;
  logic [DutyW-1:0]   duty_max;

  drive_state_t pending_outputs [$];
  drive_state_t want;
  int unsigned  mismatches;
  int unsigned  cycles;
  int unsigned  long_hold;
  int unsigned  stall_burst;
  bit           send_gaps;
  bit           recv_gaps;

  hall_commutation_with_trip_and_throttle dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .func_i            (func),
    .hall_state_i      (hall_state),
    .current_sample_i  (current_sample),
    .throttle_sample_i (throttle_sample),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .force_a_high_o    (force_a_high),
    .force_a_low_o     (force_a_low),
    .force_b_high_o    (force_b_high),
    .force_b_low_o     (force_b_low),
    .force_c_high_o    (force_c_high),
    .force_c_low_o     (force_c_low),
    .duty_compare_o    (duty_compare),
    .running_o         (running),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [DutyW-1:0] throttle_duty(input logic [SampleW-1:0] t);
    int unsigned scaled;
    if (t <= thr_low) return duty_min;
    if (t >= thr_high) return duty_max;
    scaled = (DutySlope * t + DutyBias) / DutyScale;
    return scaled[DutyW-1:0];
  endfunction

  task automatic commutate(input logic [HallW-1:0] hall);
    logic [PhaseW-1:0] pwm_ph;
    logic [PhaseW-1:0] gnd_ph;
    pwm_ph = PhaseNone;
    gnd_ph = PhaseNone;
    case (hall)
      3'd4: begin pwm_ph = PhaseC; gnd_ph = PhaseB; end
      3'd2: begin pwm_ph = PhaseB; gnd_ph = PhaseA; end
      3'd6: begin pwm_ph = PhaseC; gnd_ph = PhaseA; end
      3'd1: begin pwm_ph = PhaseA; gnd_ph = PhaseC; end
      3'd5: begin pwm_ph = PhaseA; gnd_ph = PhaseB; end
      3'd3: begin pwm_ph = PhaseB; gnd_ph = PhaseC; end
      default: ;
    endcase
    if (pwm_ph != PhaseNone) begin
      foreach (gate_force[i]) gate_force[i] = ForceHigh;
      gate_force[2 * pwm_ph]     = ForcePwm;
      gate_force[2 * pwm_ph + 1] = ForcePwm;
      gate_force[2 * gnd_ph + 1] = ForceLow;
    end
  endtask

  task automatic apply_event(input logic f, input logic [HallW-1:0] h,
                             input logic [SampleW-1:0] cur, input logic [SampleW-1:0] thr);
    if (f == FuncHall) begin
      if (drive_on) commutate(h);
    end else begin
      if (cur >= trip_level) begin
        drive_on = 1'b0;
        foreach (gate_force[i]) gate_force[i] = ForceLow;
      end
      duty_now = throttle_duty(thr);
    end
    pending_outputs.push_back('{gate_force[0], gate_force[1], gate_force[2], gate_force[3],
                                gate_force[4], gate_force[5], duty_now, drive_on});
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned exp_val);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned exp_val);
    if (got !== exp_val) report(what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        report("unexpected transfer", 1, 0);
      end else begin
        want = pending_outputs.pop_front();
        check_field("force_a_high", force_a_high, want.a_high);
        check_field("force_a_low", force_a_low, want.a_low);
        check_field("force_b_high", force_b_high, want.b_high);
        check_field("force_b_low", force_b_low, want.b_low);
        check_field("force_c_high", force_c_high, want.c_high);
        check_field("force_c_low", force_c_low, want.c_low);
        check_field("duty_compare", duty_compare, want.duty);
        check_field("running", running, want.run);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("[hall_commutation_with_trip_and_throttle] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (long_hold != 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else if (stall_burst != 0) begin
      stall_burst--;
      out_stall <= 1'b1;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      stall_burst = $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(input logic f, input logic [HallW-1:0] h,
                            input logic [SampleW-1:0] cur, input logic [SampleW-1:0] thr);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    func            <= f;
    hall_state      <= h;
    current_sample  <= cur;
    throttle_sample <= thr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_event(f, h, cur, thr);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (SettleDelay) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CfgTripThreshold: trip_level = val;
      CfgThrottleLow:   thr_low    = val;
      CfgThrottleHigh:  thr_high   = val;
      CfgDutyFloor:     duty_min   = val[DutyW-1:0];
      CfgDutyCeiling:   duty_max   = val[DutyW-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [SampleW-1:0] trip, input logic [SampleW-1:0] lo,
                           input logic [SampleW-1:0] hi, input logic [DutyW-1:0] dmin,
                           input logic [DutyW-1:0] dmax);
    drain();
    write_reg(CfgTripThreshold, trip);
    write_reg(CfgThrottleLow, lo);
    write_reg(CfgThrottleHigh, hi);
    write_reg(CfgDutyFloor, CfgDataW'(dmin));
    write_reg(CfgDutyCeiling, CfgDataW'(dmax));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SampleW'(SampleMax);
      default: return SampleW'($urandom_range(0, SampleMax));
    endcase
  endfunction

  function automatic logic [DutyW-1:0] pick_duty();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return DutyW'(DutyMax);
      default: return DutyW'($urandom_range(0, DutyMax));
    endcase
  endfunction

  function automatic logic [SampleW-1:0] pick_throttle();
    int level;
    case ($urandom_range(0, 3))
      0:       level = int'(thr_low) + int'($urandom_range(0, 4)) - 2;
      1:       level = int'(thr_high) + int'($urandom_range(0, 4)) - 2;
      default: level = int'($urandom_range(0, SampleMax));
    endcase
    if (level < 0) level = 0;
    if (level > int'(SampleMax)) level = int'(SampleMax);
    return SampleW'(level);
  endfunction

  // keep the current sample below the trip level unless a trip is wanted
  task automatic random_event(input bit allow_trip);
    logic               f;
    logic [HallW-1:0]   h;
    logic [SampleW-1:0] cur;
    h = HallW'($urandom_range(1, 6));
    if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1) ? HallAllHigh : HallAllLow;
    f = ($urandom_range(0, 2) == 0) ? FuncAdc : FuncHall;
    if (allow_trip || f == FuncHall) cur = SampleW'($urandom_range(0, SampleMax));
    else cur = SampleW'($urandom_range(0, trip_level - 1));
    send_event(f, h, cur, pick_throttle());
  endtask

  task automatic test_hall_map();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    send_event(FuncHall, HallAllLow, pick_level(), pick_level());
    send_event(FuncHall, HallAllHigh, pick_level(), pick_level());
    for (int h = 1; h <= 6; h++) send_event(FuncHall, HallW'(h), pick_level(), pick_level());
    send_event(FuncHall, HallAllLow, pick_level(), pick_level());
    send_event(FuncHall, HallAllHigh, pick_level(), pick_level());
    drain();
  endtask

  task automatic test_throttle_map();
    send_event(FuncAdc, HallAllHigh, '0, '0);
    send_event(FuncAdc, HallAllLow, SampleW'(trip_level - 1), thr_low);
    send_event(FuncAdc, 3'd5, '0, SampleW'(thr_low + 1));
    send_event(FuncAdc, 3'd2, 12'd1000, 12'd1230);
    send_event(FuncAdc, 3'd1, SampleW'(trip_level - 1), SampleW'(thr_high - 1));
    send_event(FuncAdc, 3'd6, '0, thr_high);
    send_event(FuncAdc, 3'd3, 12'd2047, SampleW'(SampleMax));
    drain();
  endtask

  task automatic test_setting_extremes();
    configure(SampleW'(SampleMax), '0, SampleW'(SampleMax), '0, DutyW'(DutyMax));
    send_event(FuncAdc, HallAllLow, 12'd4094, '0);
    send_event(FuncAdc, HallAllLow, 12'd1, 12'd1);
    send_event(FuncAdc, HallAllLow, 12'd2730, 12'd4094);
    // crossed limits: the low test wins
    configure(SampleW'(SampleMax), SampleW'(SampleMax), '0, DutyW'(DutyMax), '0);
    send_event(FuncAdc, HallAllHigh, 12'd1365, '0);
    send_event(FuncAdc, HallAllHigh, 12'd0, 12'd2000);
    send_event(FuncAdc, HallAllHigh, 12'd3, SampleW'(SampleMax));
    drain();
  endtask

  task automatic test_random_settings();
    logic [SampleW-1:0] trip;
    for (int phase = 0; phase < 8; phase++) begin
      trip = (phase % 2 == 0) ? SampleW'(SampleMax) : SampleW'($urandom_range(1, SampleMax));
      configure(trip, pick_level(), pick_level(), pick_duty(), pick_duty());
      send_gaps = (phase % 3 != 2);
      recv_gaps = (phase % 4 != 3);
      repeat (100) random_event(1'b0);
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    long_hold = LongHold;
    repeat (16) random_event(1'b0);
    drain();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    repeat (12) random_event(1'b0);
    drain();
  endtask

  task automatic test_overcurrent_trip();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    configure(SampleW'(SampleMax), ThrottleLowRst, ThrottleHighRst, DutyFloorRst,
              DutyCeilingRst);
    send_event(FuncHall, 3'd1, pick_level(), pick_level());
    send_event(FuncAdc, HallAllLow, 12'd4094, 12'd2000);
    send_event(FuncAdc, HallAllLow, SampleW'(SampleMax), 12'd1500);
    send_event(FuncHall, 3'd3, pick_level(), pick_level());
    send_event(FuncAdc, 3'd4, SampleW'(SampleMax), 12'd3000);
    configure('0, pick_level(), pick_level(), pick_duty(), pick_duty());
    send_event(FuncAdc, HallAllHigh, '0, pick_throttle());
    repeat (30) random_event(1'b1);
    drain();
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    func            = FuncHall;
    hall_state      = '0;
    current_sample  = '0;
    throttle_sample = '0;
    out_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CfgTripThreshold;
    cfg_data        = '0;
    foreach (gate_force[i]) gate_force[i] = ForceNone;
    drive_on    = 1'b1;
    duty_now    = DutyValueRst;
    trip_level  = TripThresholdRst;
    thr_low     = ThrottleLowRst;
    thr_high    = ThrottleHighRst;
    duty_min    = DutyFloorRst;
    duty_max    = DutyCeilingRst;
    mismatches  = 0;
    cycles      = 0;
    long_hold   = 0;
    stall_burst = 0;
    send_gaps   = 1'b0;
    recv_gaps   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_hall_map();
    test_throttle_map();
    test_setting_extremes();
    test_random_settings();
    test_backpressure();
    test_overcurrent_trip();

    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("[hall_commutation_with_trip_and_throttle] OK");
    end else begin
      $display("[hall_commutation_with_trip_and_throttle] ERROR");
    end
    $finish;
  end

endmodule
